/* hw/rtl/itoa_pkg.sv */
// ----------------------------------------------------------------------------
// itoa_pkg
// shared widths, ascii codes and the conversion pipeline's data type
// ----------------------------------------------------------------------------
package itoa_pkg;

  localparam int unsigned VALUE_W        = 32;
  localparam int unsigned CHAR_W         = 8;
  localparam int unsigned BCD_DIGITS     = 10;
  localparam int unsigned DIGIT_IDX_W    = $clog2(BCD_DIGITS);
  localparam int unsigned BITS_PER_STAGE = 8;
  localparam int unsigned DABBLE_STAGES  = VALUE_W / BITS_PER_STAGE;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] ASCII_NINE  = 8'd57;
  localparam logic [CHAR_W-1:0] ASCII_ONE   = 8'd49;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;

  // ten packed decimal digits, digit 0 least significant
  typedef logic [BCD_DIGITS-1:0][3:0] bcd_t;

  // one request in flight through the double-dabble pipeline
  typedef struct packed {
    logic               neg;
    bcd_t               bcd;
    logic [VALUE_W-1:0] bin;
  } dabble_t;

endpackage

/* hw/rtl/signed_int_to_decimal_ascii.sv */
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// signed 32-bit integer to decimal ascii text, one character per request
// ----------------------------------------------------------------------------
// Each accepted value produces its decimal text as 1 to 11 output requests,
// most significant character first: a leading '-' for negative values, no
// leading zeros, a lone '0' for zero, and last_char_o set on the final digit.
// The most negative value gives "-2147483648". Conversion runs through an
// input register and four double-dabble stages of eight bits each, then the
// serialiser's output register. The serialiser puts out one character a
// cycle while out_stall_i is low; a value's text is 2 to 11 characters for
// negative values and 1 to 10 otherwise. The pipeline accepts new values
// while the serialiser is still sending an earlier value's text. Up to five
// further values queue in the pipeline while the output stalls; nothing is
// dropped or repeated.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // input requests
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [itoa_pkg::VALUE_W-1:0]   value_i,
  // output requests
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic        [itoa_pkg::CHAR_W-1:0]    character_o,
  output logic                                  last_char_o
);

  // input register
  logic                          in_valid_q, in_valid_d;
  logic [itoa_pkg::VALUE_W-1:0]  in_value_q, in_value_d;
  logic                          in_ready;

  // stage 0 feeds the first dabble stage, stage k its successor
  logic              stg_valid [itoa_pkg::DABBLE_STAGES+1];
  logic              stg_ready [itoa_pkg::DABBLE_STAGES+1];
  itoa_pkg::dabble_t stg_data  [itoa_pkg::DABBLE_STAGES+1];

  assign in_ready   = !in_valid_q || stg_ready[0];
  assign in_stall_o = !in_ready;

  always_comb begin
    in_valid_d = in_valid_q;
    in_value_d = in_value_q;
    if (in_ready) begin
      in_valid_d = in_valid_i;
      if (in_valid_i) begin
        in_value_d = value_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_value_q <= in_value_d;
  end

  // magnitude as unsigned, so the most negative value maps to 2^31 intact
  always_comb begin
    stg_valid[0]    = in_valid_q;
    stg_data[0].neg = in_value_q[itoa_pkg::VALUE_W-1];
    stg_data[0].bcd = '0;
    stg_data[0].bin = in_value_q[itoa_pkg::VALUE_W-1] ? (~in_value_q + 1'b1) : in_value_q;
  end

  // binary to bcd, eight shift steps per stage
  for (genvar k = 0; k < itoa_pkg::DABBLE_STAGES; k++) begin : g_dabble
    itoa_dabble_stage u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (stg_valid[k]),
      .in_ready_o  (stg_ready[k]),
      .in_data_i   (stg_data[k]),
      .out_valid_o (stg_valid[k+1]),
      .out_ready_i (stg_ready[k+1]),
      .out_data_o  (stg_data[k+1])
    );
  end

  // sign and digits out, one a cycle while the output is not stalled, from a registered output
  itoa_serialiser u_serialiser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (stg_valid[itoa_pkg::DABBLE_STAGES]),
    .in_ready_o  (stg_ready[itoa_pkg::DABBLE_STAGES]),
    .in_data_i   (stg_data[itoa_pkg::DABBLE_STAGES]),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .character_o (character_o),
    .last_char_o (last_char_o)
  );

endmodule

/* hw/rtl/itoa_dabble_stage.sv */
// ----------------------------------------------------------------------------
// itoa_dabble_stage
// one registered stage of shift-and-add-3 binary to bcd conversion
// ----------------------------------------------------------------------------
module itoa_dabble_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  itoa_pkg::dabble_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output itoa_pkg::dabble_t out_data_o
);

  logic              valid_q, valid_d;
  itoa_pkg::dabble_t data_q, data_d;
  itoa_pkg::dabble_t work;

  always_comb begin
    work = in_data_i;
    for (int s = 0; s < itoa_pkg::BITS_PER_STAGE; s++) begin
      for (int d = 0; d < itoa_pkg::BCD_DIGITS; d++) begin
        if (work.bcd[d] >= 4'd5) begin
          work.bcd[d] = work.bcd[d] + 4'd3;
        end
      end
      {work.bcd, work.bin} = {work.bcd, work.bin} << 1;
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
      if (in_valid_i) begin
        data_d = work;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

/* hw/rtl/itoa_serialiser.sv */
// ----------------------------------------------------------------------------
// itoa_serialiser
// turns one bcd word into a sign and digit stream, one character a cycle unless stalled
// ----------------------------------------------------------------------------
module itoa_serialiser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  itoa_pkg::dabble_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [itoa_pkg::CHAR_W-1:0]   character_o,
  output logic                          last_char_o
);

  // index of the most significant non-zero digit, zero when all are zero
  function automatic logic [itoa_pkg::DIGIT_IDX_W-1:0] lead_digit(itoa_pkg::bcd_t b);
    logic [itoa_pkg::DIGIT_IDX_W-1:0] idx;
    idx = '0;
    for (int d = 0; d < itoa_pkg::BCD_DIGITS; d++) begin
      if (b[d] != 4'd0) begin
        idx = itoa_pkg::DIGIT_IDX_W'(d);
      end
    end
    return idx;
  endfunction

  logic                             valid_q, valid_d;
  logic                             pend_q, pend_d;
  logic [itoa_pkg::CHAR_W-1:0]      char_q, char_d;
  logic                             last_q, last_d;
  itoa_pkg::bcd_t                   bcd_q, bcd_d;
  logic [itoa_pkg::DIGIT_IDX_W-1:0] pos_q, pos_d;
  logic [itoa_pkg::DIGIT_IDX_W-1:0] lead;
  logic                             take;

  assign take       = valid_q && !out_stall_i;
  assign in_ready_o = !valid_q || (take && !pend_q);
  assign lead       = lead_digit(in_data_i.bcd);

  always_comb begin
    valid_d = valid_q;
    pend_d  = pend_q;
    char_d  = char_q;
    last_d  = last_q;
    bcd_d   = bcd_q;
    pos_d   = pos_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
      bcd_d   = in_data_i.bcd;
      if (in_data_i.neg) begin
        char_d = itoa_pkg::ASCII_MINUS;
        last_d = 1'b0;
        pos_d  = lead;
        pend_d = 1'b1;
      end else begin
        char_d = itoa_pkg::ASCII_ZERO + {4'd0, in_data_i.bcd[lead]};
        last_d = (lead == '0);
        pos_d  = lead - 1'b1;
        pend_d = (lead != '0);
      end
    end else if (take && pend_q) begin
      char_d = itoa_pkg::ASCII_ZERO + {4'd0, bcd_q[pos_q]};
      last_d = (pos_q == '0);
      pos_d  = pos_q - 1'b1;
      pend_d = (pos_q != '0);
    end else if (take) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
    bcd_q  <= bcd_d;
    pos_q  <= pos_d;
  end

  assign out_valid_o = valid_q;
  assign character_o = char_q;
  assign last_char_o = last_q;

endmodule

/* hw/rtl/itoa_checker.sv */
// ----------------------------------------------------------------------------
// itoa_checker
// port-level checks on the character stream of the converter
// ----------------------------------------------------------------------------
module itoa_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic        [itoa_pkg::CHAR_W-1:0]  character_o,
  input logic                                last_char_o
);

  logic out_take;
  logic first_q;
  logic after_minus_q;

  assign out_take = out_valid_o && !out_stall_i;

  // first_q: next character opens a new number; after_minus_q: follows a sign
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q       <= 1'b1;
      after_minus_q <= 1'b0;
    end else if (out_take) begin
      first_q       <= last_char_o;
      after_minus_q <= (character_o == itoa_pkg::ASCII_MINUS);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(character_o) && $stable(last_char_o))
    else $error("output request changed while stalled");

  a_char_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (character_o == itoa_pkg::ASCII_MINUS) ||
                    (character_o >= itoa_pkg::ASCII_ZERO && character_o <= itoa_pkg::ASCII_NINE))
    else $error("character outside sign and digits");

  a_sign_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && character_o == itoa_pkg::ASCII_MINUS |-> first_q && !last_char_o)
    else $error("sign not at the head of a number or marked last");

  a_no_lead_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && after_minus_q |->
      character_o >= itoa_pkg::ASCII_ONE && character_o <= itoa_pkg::ASCII_NINE)
    else $error("sign not followed by a non-zero digit");

  a_zero_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && first_q && character_o == itoa_pkg::ASCII_ZERO |-> last_char_o)
    else $error("leading zero in a number");

endmodule

bind signed_int_to_decimal_ascii itoa_checker u_itoa_checker (.*);

/* bench/signed_int_to_decimal_ascii_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_test
// self-checking bench for the signed integer to decimal text converter
// ----------------------------------------------------------------------------
// Drives signed 32-bit values into the converter and predicts each value's
// text ('-' for negatives, no leading zeros, a lone '0' for zero, last flag
// on the final digit). Every output request is checked against the oldest
// predicted character. A short directed set covers the corner values, then
// random values follow, mostly spread evenly over digit counts. Random
// idling on both channels falls away in the final stretch of the run.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_test;

  localparam int unsigned DECIMAL_RADIX  = 10;
  localparam int          RANDOM_VALUES  = 440;
  localparam int          QUIET_TAIL     = 60;    // last values sent with no idling
  localparam int          STRETCH_LEN    = 40;    // values per idling stretch
  localparam int          IDLE_LIMIT     = 1000;  // cycles with no request moving
  localparam int          SETTLE_CYCLES  = 20;    // pipeline depth plus margin

  // one predicted output request
  typedef struct {
    logic [itoa_pkg::CHAR_W-1:0] character;
    logic                        last_char;
  } text_char_t;

  // ------------------------------------------------------------------------
  // text scoreboard: predicts the characters of each accepted value and
  // checks output requests against them in order
  // ------------------------------------------------------------------------
  class TextScoreboard;
    text_char_t pending_chars[$];
    int         errors;
    int         values_seen;
    int         chars_checked;
    int         negatives_seen;
    int         longest_seen;

    function void note_value(logic [itoa_pkg::VALUE_W-1:0] value);
      logic [itoa_pkg::VALUE_W-1:0] magnitude;
      logic [3:0]                   digits[itoa_pkg::BCD_DIGITS];
      int                           n_digits;
      text_char_t                   entry;
      // two's complement negation; the most negative value stays 2^31,
      // which read unsigned is exactly its magnitude
      magnitude = value[itoa_pkg::VALUE_W-1] ? (~value + 1'b1) : value;
      n_digits  = 0;
      // digits least significant first, zero still gives one digit
      do begin
        digits[n_digits] = 4'(magnitude % DECIMAL_RADIX);
        n_digits++;
        magnitude = magnitude / DECIMAL_RADIX;
      end while (magnitude != 0);
      if (value[itoa_pkg::VALUE_W-1]) begin
        entry.character = itoa_pkg::ASCII_MINUS;
        entry.last_char = 1'b0;
        pending_chars.push_back(entry);
        negatives_seen++;
      end
      for (int i = n_digits - 1; i >= 0; i--) begin
        entry.character = itoa_pkg::ASCII_ZERO + itoa_pkg::CHAR_W'(digits[i]);
        entry.last_char = (i == 0);
        pending_chars.push_back(entry);
      end
      if (n_digits + int'(value[itoa_pkg::VALUE_W-1]) == itoa_pkg::BCD_DIGITS + 1)
        longest_seen++;
      values_seen++;
    endfunction

    function void check_char(logic [itoa_pkg::CHAR_W-1:0] character, logic last_char);
      text_char_t want;
      if (pending_chars.size() == 0) begin
        $error("unexpected output request: character %0d, last_char %0d",
               character, last_char);
        errors++;
        return;
      end
      want = pending_chars.pop_front();
      chars_checked++;
      if (character !== want.character) begin
        $error("character: expected %0d, actual %0d", want.character, character);
        errors++;
      end
      if (last_char !== want.last_char) begin
        $error("last_char: expected %0d, actual %0d", want.last_char, last_char);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending_chars.size();
    endfunction
  endclass

  // ------------------------------------------------------------------------
  // clock, reset and block ports
  // ------------------------------------------------------------------------
  logic                                 clk_i;
  logic                                 rst_ni;
  logic                                 in_valid_i;
  logic                                 in_stall_o;
  logic signed [itoa_pkg::VALUE_W-1:0]  value_i;
  logic                                 out_valid_o;
  logic                                 out_stall_i;
  logic        [itoa_pkg::CHAR_W-1:0]   character_o;
  logic                                 last_char_o;

  TextScoreboard text_board;
  bit            idling_on;     // shared by sender and receiver
  int            stall_left;
  int            quiet_cycles;

  signed_int_to_decimal_ascii dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .character_o (character_o),
    .last_char_o (last_char_o)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ------------------------------------------------------------------------
  // monitor: sample both channels at the edge, before the block updates
  // ------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) text_board.note_value(value_i);
      if (out_valid_o && !out_stall_i) text_board.check_char(character_o, last_char_o);
    end
  end

  // watchdog: a long run of cycles where no request moves on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: random stall bursts while idling is on
  always @(posedge clk_i) begin
    if (stall_left == 0 && idling_on && $urandom_range(0, 5) == 0)
      stall_left = $urandom_range(1, 6);
    out_stall_i <= (stall_left != 0);
    if (stall_left != 0) stall_left = stall_left - 1;
  end

  // ------------------------------------------------------------------------
  // sender tasks
  // ------------------------------------------------------------------------

  // present one value and hold it until accepted; valid stays high so a
  // following request can go out back to back
  task automatic send_value(input logic [itoa_pkg::VALUE_W-1:0] value);
    int gap;
    if (idling_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= value;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // hold off the sender until every predicted character has come out
  task automatic drain_text();
    in_valid_i <= 1'b0;
    while (text_board.outstanding() != 0) @(posedge clk_i);
  endtask

  // random value with an even spread of digit counts, some fully random
  // words and the odd extreme
  function automatic logic [itoa_pkg::VALUE_W-1:0] pick_value();
    longint lo_mag;
    longint hi_mag;
    longint magnitude;
    int     n_digits;
    int     pick;
    bit     negative;
    pick     = $urandom_range(0, 99);
    negative = $urandom_range(0, 1);
    if (pick < 15) return $urandom();
    if (pick < 20) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    n_digits = $urandom_range(1, itoa_pkg::BCD_DIGITS);
    lo_mag   = (n_digits == 1) ? 0 : 10 ** (n_digits - 1);
    hi_mag   = 10 ** n_digits - 1;
    // ten digits only reach 2^31 - 1, or 2^31 for a negative value
    if (n_digits == itoa_pkg::BCD_DIGITS)
      hi_mag = negative ? 64'd2147483648 : 64'd2147483647;
    magnitude = lo_mag + longint'($urandom_range(0, 32'(hi_mag - lo_mag)));
    return negative ? itoa_pkg::VALUE_W'(-magnitude) : itoa_pkg::VALUE_W'(magnitude);
  endfunction

  // ------------------------------------------------------------------------
  // stimulus
  // ------------------------------------------------------------------------
  logic [itoa_pkg::VALUE_W-1:0] corner_values[$] = '{
    32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
    -32'sd5, 32'd7, 32'd2147483647, 32'h8000_0000, 32'h8000_0001,
    32'd1000000000, 32'd999999999, -32'sd999999999, -32'sd1000000000,
    32'd1234567890, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF, 32'hFFFF_0000
  };

  initial begin
    text_board   = new();
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    value_i      = '0;
    out_stall_i  = 1'b0;
    idling_on    = 1'b0;
    stall_left   = 0;
    quiet_cycles = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners, first without idling, then every fourth one again with it
    foreach (corner_values[i]) send_value(corner_values[i]);
    drain_text();
    idling_on = 1'b1;
    foreach (corner_values[i]) if (i % 4 == 0) send_value(corner_values[i]);

    // random values, idling switched per stretch, quiet at the very end
    for (int n = 0; n < RANDOM_VALUES; n++) begin
      if (n % STRETCH_LEN == 0) idling_on = ($urandom_range(0, 3) != 0);
      if (n >= RANDOM_VALUES - QUIET_TAIL) idling_on = 1'b0;
      if ($urandom_range(0, 49) == 0) drain_text();
      send_value(pick_value());
    end
    in_valid_i <= 1'b0;

    // let the pipeline empty, then give stray requests a chance to show
    while (text_board.outstanding() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("converted %0d values (%0d negative, %0d of eleven characters)",
             text_board.values_seen, text_board.negatives_seen,
             text_board.longest_seen);
    $display("checked %0d characters with random stalls on both channels",
             text_board.chars_checked);
    if (text_board.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
